// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the RTL. Each expects aclk and aresetn in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME_CYCLE(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("same-cycle assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT_CYCLE(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("next-cycle assertion failed");

`else

`define ASSERT_SAME_CYCLE(lbl, ante, cons)
`define ASSERT_NEXT_CYCLE(lbl, ante, cons)

`endif

`endif

// ----- hw/rtl/dcid_pkg.sv -----
package dcid_pkg;

    // Command codes carried in s_tuser.
    localparam logic [2:0] CMD_TICK   = 3'd0;
    localparam logic [2:0] CMD_FRAME  = 3'd1;
    localparam logic [2:0] CMD_START  = 3'd2;
    localparam logic [2:0] CMD_ASSIGN = 3'd3;
    localparam logic [2:0] CMD_CLEAR  = 3'd4;

    // Discovery phases.
    localparam logic [2:0] PH_WAIT_EN     = 3'd0;
    localparam logic [2:0] PH_CHECK       = 3'd1;
    localparam logic [2:0] PH_ANNOUNCE    = 3'd2;
    localparam logic [2:0] PH_WAIT_ASSIGN = 3'd3;
    localparam logic [2:0] PH_REJOIN      = 3'd4;
    localparam logic [2:0] PH_ENABLED     = 3'd5;

    // Frame kinds to transmit.
    localparam logic [1:0] SEND_NONE     = 2'd0;
    localparam logic [1:0] SEND_ANNOUNCE = 2'd1;
    localparam logic [1:0] SEND_ACK      = 2'd2;
    localparam logic [1:0] SEND_REJOIN   = 2'd3;

    // Payload lengths.
    localparam logic [2:0] LEN_NONE     = 3'd0;
    localparam logic [2:0] LEN_ANNOUNCE = 3'd6;
    localparam logic [2:0] LEN_ID_FRAME = 3'd7;
    localparam logic [3:0] ASSIGN_MIN_LEN = 4'd7;

    // Configuration register indexes.
    localparam logic [2:0] REG_STATION_MAC = 3'd0;
    localparam logic [2:0] REG_SAVED_ID    = 3'd1;
    localparam logic [2:0] REG_RETRY       = 3'd2;
    localparam logic [2:0] REG_TIMEOUT     = 3'd3;
    localparam logic [2:0] REG_ASSIGN_FID  = 3'd4;

    localparam int TICK_CFG_W = 20;

    typedef logic [2:0]  cfg_index_t;
    typedef logic [47:0] cfg_data_t;
    typedef logic [71:0] in_data_t;
    typedef logic [23:0] out_data_t;

endpackage

// ----- hw/rtl/daisy_chain_id_discovery.sv -----
// Channel   | Direction | Handshake          | Payload
// s_        | in        | s_tvalid/s_tready  | tuser cmd, tdata frame and id fields
// m_        | out       | m_tvalid/m_tready  | tuser send kind, tdata send and status
// cfg_      | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One item per cycle sustained while m_ is ready; an accepted item goes from the input
// register through one pass of sequencer logic into the result register, where m_
// takes it. Each item gives exactly one result. aresetn is synchronous and clears the
// phase, counters, pending assign and node id. A stalled m_ side holds the result; the
// input register still takes one more item before s_tready falls. Configuration writes
// are taken in any cycle.
`include "assert_macros.svh"

module daisy_chain_id_discovery #(
    parameter int COUNTER_WIDTH = 20
) (
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   s_tvalid,
    output logic                   s_tready,
    // aei_level, frame_ident, frame_length, frame_mac, id_value
    input  dcid_pkg::in_data_t     s_tdata,
    // cmd
    input  logic [2:0]             s_tuser,

    output logic                   m_tvalid,
    input  logic                   m_tready,
    // send_length, send_id, aeo_level, node_id, phase, id_store
    output dcid_pkg::out_data_t    m_tdata,
    // send_kind
    output logic [1:0]             m_tuser,

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  dcid_pkg::cfg_index_t   cfg_index,
    input  dcid_pkg::cfg_data_t    cfg_data
);
    import dcid_pkg::*;

    localparam int CW    = COUNTER_WIDTH;
    localparam int CMP_W = (CW > TICK_CFG_W) ? CW : TICK_CFG_W;
    localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};

    // Configuration registers.
    logic [47:0]           mac_reg;
    logic [TICK_CFG_W-1:0] retry_reg;
    logic [TICK_CFG_W-1:0] timeout_reg;
    logic [10:0]           assign_fid_reg;

    // Input register.
    logic        in_valid_reg;
    logic [2:0]  in_cmd_reg;
    logic        in_aei_reg;
    logic [10:0] in_fid_reg;
    logic [3:0]  in_len_reg;
    logic [47:0] in_mac_reg;
    logic [7:0]  in_idv_reg;

    // Sequencer state.
    logic [2:0]    phase_reg, phase_next;
    logic [7:0]    cur_id_reg, cur_id_next;
    logic          pend_valid_reg, pend_valid_next;
    logic [7:0]    pend_id_reg, pend_id_next;
    logic          aeo_reg, aeo_next;
    logic [CW-1:0] since_ann_reg, since_ann_next;
    logic [CW-1:0] since_start_reg, since_start_next;

    // Result register.
    logic       out_valid_reg;
    logic [1:0] out_kind_reg, out_kind_next;
    logic [2:0] out_len_reg, out_len_next;
    logic [7:0] out_sid_reg, out_sid_next;
    logic       out_store_reg, out_store_next;
    logic       out_aeo_reg;
    logic [7:0] out_node_reg;
    logic [2:0] out_phase_reg;

    logic          advance;
    logic [CW-1:0] ann_inc;
    logic [CW-1:0] start_inc;
    logic          frame_ok;

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {out_store_reg, out_phase_reg, out_node_reg,
                       out_aeo_reg, out_sid_reg, out_len_reg};

    assign ann_inc   = (since_ann_reg == CNT_MAX) ? CNT_MAX : since_ann_reg + CW'(1);
    assign start_inc = (since_start_reg == CNT_MAX) ? CNT_MAX : since_start_reg + CW'(1);
    assign frame_ok  = (in_fid_reg == assign_fid_reg) && (in_len_reg >= ASSIGN_MIN_LEN)
                       && (in_mac_reg == mac_reg);

    always_comb begin
        phase_next       = phase_reg;
        cur_id_next      = cur_id_reg;
        pend_valid_next  = pend_valid_reg;
        pend_id_next     = pend_id_reg;
        aeo_next         = aeo_reg;
        since_ann_next   = since_ann_reg;
        since_start_next = since_start_reg;
        out_kind_next    = SEND_NONE;
        out_len_next     = LEN_NONE;
        out_sid_next     = 8'd0;
        out_store_next   = 1'b0;

        unique case (in_cmd_reg)
            CMD_TICK: begin
                since_ann_next   = ann_inc;
                since_start_next = start_inc;
                unique case (phase_reg)
                    PH_WAIT_EN: begin
                        if (in_aei_reg) begin
                            phase_next = PH_CHECK;
                        end
                    end
                    PH_CHECK: begin
                        if (cur_id_reg != 8'd0) begin
                            phase_next = PH_REJOIN;
                        end else begin
                            phase_next     = PH_ANNOUNCE;
                            since_ann_next = CNT_MAX;
                        end
                    end
                    PH_ANNOUNCE: begin
                        if ((CMP_W'(ann_inc) >= CMP_W'(retry_reg)) || (ann_inc == CNT_MAX)) begin
                            out_kind_next    = SEND_ANNOUNCE;
                            out_len_next     = LEN_ANNOUNCE;
                            since_ann_next   = '0;
                            since_start_next = '0;
                            phase_next       = PH_WAIT_ASSIGN;
                        end
                    end
                    PH_WAIT_ASSIGN: begin
                        if (pend_valid_reg) begin
                            pend_valid_next = 1'b0;
                            cur_id_next     = pend_id_reg;
                            out_store_next  = 1'b1;
                            out_kind_next   = SEND_ACK;
                            out_len_next    = LEN_ID_FRAME;
                            out_sid_next    = pend_id_reg;
                            aeo_next        = 1'b1;
                            phase_next      = PH_ENABLED;
                        end else if (CMP_W'(start_inc) >= CMP_W'(timeout_reg)) begin
                            phase_next = PH_ANNOUNCE;
                        end
                    end
                    PH_REJOIN: begin
                        out_kind_next = SEND_REJOIN;
                        out_len_next  = LEN_ID_FRAME;
                        out_sid_next  = cur_id_reg;
                        aeo_next      = 1'b1;
                        phase_next    = PH_ENABLED;
                    end
                    default: begin
                    end
                endcase
            end
            CMD_FRAME: begin
                if (frame_ok) begin
                    pend_id_next    = in_idv_reg;
                    pend_valid_next = 1'b1;
                end
            end
            CMD_START: begin
                since_start_next = '0;
                phase_next       = PH_WAIT_EN;
            end
            CMD_ASSIGN: begin
                cur_id_next    = in_idv_reg;
                out_store_next = 1'b1;
                if (phase_reg != PH_ENABLED) begin
                    aeo_next   = 1'b1;
                    phase_next = PH_ENABLED;
                end
            end
            CMD_CLEAR: begin
                cur_id_next     = 8'd0;
                out_store_next  = 1'b1;
                aeo_next        = 1'b0;
                pend_valid_next = 1'b0;
                phase_next      = PH_WAIT_EN;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_cmd_reg <= s_tuser;
            in_aei_reg <= s_tdata[0];
            in_fid_reg <= s_tdata[11:1];
            in_len_reg <= s_tdata[15:12];
            in_mac_reg <= s_tdata[63:16];
            in_idv_reg <= s_tdata[71:64];
        end
        if (advance) begin
            out_kind_reg  <= out_kind_next;
            out_len_reg   <= out_len_next;
            out_sid_reg   <= out_sid_next;
            out_store_reg <= out_store_next;
            out_aeo_reg   <= aeo_next;
            out_node_reg  <= cur_id_next;
            out_phase_reg <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            phase_reg       <= PH_WAIT_EN;
            cur_id_reg      <= 8'd0;
            pend_valid_reg  <= 1'b0;
            pend_id_reg     <= 8'd0;
            aeo_reg         <= 1'b0;
            since_ann_reg   <= '0;
            since_start_reg <= '0;
            mac_reg         <= 48'd0;
            retry_reg       <= TICK_CFG_W'(1000);
            timeout_reg     <= TICK_CFG_W'(5000);
            assign_fid_reg  <= 11'd129;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (advance) begin
                phase_reg       <= phase_next;
                pend_valid_reg  <= pend_valid_next;
                pend_id_reg     <= pend_id_next;
                aeo_reg         <= aeo_next;
                since_ann_reg   <= since_ann_next;
                since_start_reg <= since_start_next;
            end
            // Writing the saved id loads the current id, ahead of any sequencer update.
            if (cfg_valid && (cfg_index == REG_SAVED_ID)) begin
                cur_id_reg <= cfg_data[7:0];
            end else if (advance) begin
                cur_id_reg <= cur_id_next;
            end
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_STATION_MAC: mac_reg        <= cfg_data;
                    REG_RETRY:       retry_reg      <= cfg_data[TICK_CFG_W-1:0];
                    REG_TIMEOUT:     timeout_reg    <= cfg_data[TICK_CFG_W-1:0];
                    REG_ASSIGN_FID:  assign_fid_reg <= cfg_data[10:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    `ASSERT_SAME_CYCLE(a_ack_stores_id,
        out_valid_reg && (out_kind_reg == SEND_ACK),
        out_store_reg && out_aeo_reg && (out_phase_reg == PH_ENABLED))
    `ASSERT_SAME_CYCLE(a_none_is_empty,
        out_valid_reg && (out_kind_reg == SEND_NONE),
        (out_len_reg == LEN_NONE) && (out_sid_reg == 8'd0))
    `ASSERT_NEXT_CYCLE(a_result_tracks_phase,
        advance && aresetn,
        out_valid_reg && (out_phase_reg == phase_reg))

endmodule
